[sv/sorted_priority_queue_macros.svh]
// ----------------------------------------------------------------------------
// sorted_priority_queue_macros.svh
// Assertion shorthands used by the priority queue checker.
// ----------------------------------------------------------------------------
`ifndef SORTED_PRIORITY_QUEUE_MACROS_SVH
`define SORTED_PRIORITY_QUEUE_MACROS_SVH

// Check a property on every clock edge outside reset.
`define SPQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define SPQ_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[sv/spq_pkg.sv]
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and codes of the sorted priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

  // request kinds
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_POP    = 1'b1;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  localparam int FILL_W = 5;

  // command broadcast to every cell of the chain
  typedef struct packed {
    logic insert;
    logic pop;
  } spq_ctrl_t;

endpackage

[sv/sorted_priority_queue.sv]
// ----------------------------------------------------------------------------
// sorted_priority_queue
// Bounded max-priority queue held as a chain of cells sorted by key.
// ----------------------------------------------------------------------------
// Takes one request per cycle, insert or pop, with one result per request
// appearing on the registered output in the cycle after acceptance. Every cell
// compares its stored key against the incoming key in parallel and moves one
// place in the same cycle, so the rate is set only by the output register:
// in_ready is high whenever the result register is empty or being taken.
// Equal keys leave last-in first-out. Inserts into a full queue and pops on
// an empty queue leave the contents unchanged and are flagged in out_status.
// ----------------------------------------------------------------------------
module sorted_priority_queue #(
  parameter int DEPTH     = 16,
  parameter int KEY_WIDTH = 32,
  parameter int TAG_WIDTH = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_op,
  input  logic [KEY_WIDTH-1:0]        in_key,
  input  logic [TAG_WIDTH-1:0]        in_tag,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [KEY_WIDTH-1:0]        out_key,
  output logic [TAG_WIDTH-1:0]        out_tag,
  output logic [1:0]                  out_status,
  output logic [spq_pkg::FILL_W-1:0]  out_fill_level
);
  import spq_pkg::*;

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  logic [CNT_W-1:0]     count_r, count_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [KEY_WIDTH-1:0] out_key_r, out_key_nxt;
  logic [TAG_WIDTH-1:0] out_tag_r, out_tag_nxt;
  status_t              out_status_r, out_status_nxt;
  logic [FILL_W-1:0]    out_fill_r, out_fill_nxt;

  logic                 accept;
  logic                 is_full, is_empty;
  spq_ctrl_t            ctrl;

  logic [DEPTH-1:0]     occ;
  logic [DEPTH-1:0]     shift;
  logic [KEY_WIDTH-1:0] cell_key [DEPTH];
  logic [TAG_WIDTH-1:0] cell_tag [DEPTH];

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;
  assign is_full  = (count_r == FULL_CNT);
  assign is_empty = (count_r == '0);

  assign ctrl.insert = accept && (in_op == OP_INSERT) && !is_full;
  assign ctrl.pop    = accept && (in_op == OP_POP) && !is_empty;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    localparam logic [CNT_W-1:0] IDX = CNT_W'(i);
    logic                 l_occ, l_shift;
    logic [KEY_WIDTH-1:0] l_key, r_key;
    logic [TAG_WIDTH-1:0] l_tag, r_tag;

    assign occ[i] = (IDX < count_r);

    if (i == 0) begin : g_head
      assign l_occ   = 1'b1;
      assign l_shift = 1'b0;
      assign l_key   = '0;
      assign l_tag   = '0;
    end else begin : g_body
      assign l_occ   = occ[i-1];
      assign l_shift = shift[i-1];
      assign l_key   = cell_key[i-1];
      assign l_tag   = cell_tag[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign r_key = '0;
      assign r_tag = '0;
    end else begin : g_mid
      assign r_key = cell_key[i+1];
      assign r_tag = cell_tag[i+1];
    end

    spq_cell #(
      .KEY_WIDTH (KEY_WIDTH),
      .TAG_WIDTH (TAG_WIDTH)
    ) u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .new_key    (in_key),
      .new_tag    (in_tag),
      .occ        (occ[i]),
      .left_occ   (l_occ),
      .left_shift (l_shift),
      .left_key   (l_key),
      .left_tag   (l_tag),
      .right_key  (r_key),
      .right_tag  (r_tag),
      .shift      (shift[i]),
      .key        (cell_key[i]),
      .tag        (cell_tag[i])
    );
  end

  always_comb begin
    count_nxt = count_r;
    if (ctrl.insert) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (ctrl.pop) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_key_nxt    = out_key_r;
    out_tag_nxt    = out_tag_r;
    out_status_nxt = out_status_r;
    out_fill_nxt   = out_fill_r;
    if (accept) begin
      out_valid_nxt  = 1'b1;
      out_key_nxt    = '0;
      out_tag_nxt    = '0;
      out_status_nxt = ST_OK;
      out_fill_nxt   = FILL_W'(count_nxt);
      if (in_op == OP_POP) begin
        if (is_empty) begin
          out_status_nxt = ST_EMPTY;
        end else begin
          out_key_nxt = cell_key[0];
          out_tag_nxt = cell_tag[0];
        end
      end else if (is_full) begin
        out_status_nxt = ST_FULL;
      end
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_key_r    <= out_key_nxt;
    out_tag_r    <= out_tag_nxt;
    out_status_r <= out_status_nxt;
    out_fill_r   <= out_fill_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_key        = out_key_r;
  assign out_tag        = out_tag_r;
  assign out_status     = out_status_r;
  assign out_fill_level = out_fill_r;

endmodule

[sv/spq_cell.sv]
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted chain: holds a key and tag, shifts toward the tail
// on insert and toward the head on pop.
// ----------------------------------------------------------------------------
module spq_cell #(
  parameter int KEY_WIDTH = 32,
  parameter int TAG_WIDTH = 16
) (
  input  logic                   clk,
  input  spq_pkg::spq_ctrl_t     ctrl,
  input  logic [KEY_WIDTH-1:0]   new_key,
  input  logic [TAG_WIDTH-1:0]   new_tag,
  input  logic                   occ,
  input  logic                   left_occ,
  input  logic                   left_shift,
  input  logic [KEY_WIDTH-1:0]   left_key,
  input  logic [TAG_WIDTH-1:0]   left_tag,
  input  logic [KEY_WIDTH-1:0]   right_key,
  input  logic [TAG_WIDTH-1:0]   right_tag,
  output logic                   shift,
  output logic [KEY_WIDTH-1:0]   key,
  output logic [TAG_WIDTH-1:0]   tag
);
  import spq_pkg::*;

  logic [KEY_WIDTH-1:0] key_r, key_nxt;
  logic [TAG_WIDTH-1:0] tag_r, tag_nxt;
  logic                 take_new;

  // this entry moves back when the new key is at least as large
  assign shift    = occ && ($signed(key_r) <= $signed(new_key));
  assign take_new = !left_shift && left_occ && (shift || !occ);

  always_comb begin
    key_nxt = key_r;
    tag_nxt = tag_r;
    if (ctrl.pop) begin
      key_nxt = right_key;
      tag_nxt = right_tag;
    end else if (ctrl.insert) begin
      if (left_shift) begin
        key_nxt = left_key;
        tag_nxt = left_tag;
      end else if (take_new) begin
        key_nxt = new_key;
        tag_nxt = new_tag;
      end
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
    tag_r <= tag_nxt;
  end

  assign key = key_r;
  assign tag = tag_r;

endmodule

[sv/spq_checker.sv]
// ----------------------------------------------------------------------------
// spq_checker
// Port-level checks of the sorted priority queue, bound to the top level.
// ----------------------------------------------------------------------------
`include "sorted_priority_queue_macros.svh"

module spq_checker #(
  parameter int DEPTH     = 16,
  parameter int KEY_WIDTH = 32,
  parameter int TAG_WIDTH = 16
) (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [KEY_WIDTH-1:0]        out_key,
  input logic [TAG_WIDTH-1:0]        out_tag,
  input logic [1:0]                  out_status,
  input logic [spq_pkg::FILL_W-1:0]  out_fill_level
);
  import spq_pkg::*;

  localparam logic [FILL_W-1:0] FULL_FILL = FILL_W'(DEPTH);

  logic flagged, full_res, empty_res;

  assign flagged   = out_valid && (out_status != ST_OK);
  assign full_res  = out_valid && (out_status == ST_FULL);
  assign empty_res = out_valid && (out_status == ST_EMPTY);

  // hold a result until it is taken
  `SPQ_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid, "result dropped while stalled")

  // any flagged result carries no entry
  `SPQ_ASSERT(a_flag_zero, flagged |-> {out_key, out_tag} == '0, "flagged result has data")

  // a dropped insert reports a full queue
  `SPQ_ASSERT(a_full_level, full_res |-> out_fill_level == FULL_FILL, "full with wrong fill")

  // an empty pop reports an empty queue
  `SPQ_ASSERT(a_empty_level, empty_res |-> out_fill_level == '0, "empty with nonzero fill")

  // drop any result across reset
  `SPQ_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> !out_valid, "result valid after reset")

endmodule

bind sorted_priority_queue spq_checker #(
  .DEPTH     (DEPTH),
  .KEY_WIDTH (KEY_WIDTH),
  .TAG_WIDTH (TAG_WIDTH)
) u_spq_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_key        (out_key),
  .out_tag        (out_tag),
  .out_status     (out_status),
  .out_fill_level (out_fill_level)
);
